/* design/pls_pkg.sv */
// Shared types and constants for the positional list store.
package pls_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_INS_FIRST = 3'd0;
    localparam logic [2:0] MODE_INS_LAST  = 3'd1;
    localparam logic [2:0] MODE_INS_POS   = 3'd2;
    localparam logic [2:0] MODE_DEL_FIRST = 3'd3;
    localparam logic [2:0] MODE_DEL_LAST  = 3'd4;
    localparam logic [2:0] MODE_DEL_POS   = 3'd5;
    localparam logic [2:0] MODE_READ      = 3'd6;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_DELETE,
        CH_ROTATE
    } t_chain_op;

    typedef struct packed {
        t_chain_op        op;
        logic [IDX_W-1:0] at;
    } t_cell_ctrl;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value_in;
        logic [7:0]         position;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         element_count;
        logic               element_valid;
        logic signed [31:0] value_out;
        logic [5:0]         element_index;
        logic               last;
    } t_out_beat;

endpackage

/* design/pls_cell.sv */
// One list slot: holds a value and takes a neighbor's, the new value or the head's on chain commands.
module pls_cell (
    input  logic                     i_clk,
    input  pls_pkg::t_cell_ctrl      i_ctrl,
    input  logic [pls_pkg::IDX_W-1:0] i_index,
    input  logic signed [31:0]       i_left,
    input  logic signed [31:0]       i_right,
    input  logic signed [31:0]       i_head,
    input  logic signed [31:0]       i_new,
    output logic signed [31:0]       o_value
);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctrl.op)
            pls_pkg::CH_INSERT: begin
                if (i_index > i_ctrl.at) begin
                    n_value = i_left;
                end else if (i_index == i_ctrl.at) begin
                    n_value = i_new;
                end
            end
            pls_pkg::CH_DELETE: begin
                if (i_index >= i_ctrl.at) begin
                    n_value = i_right;
                end
            end
            // read-out: shift toward the head, old head wraps to the tail slot
            pls_pkg::CH_ROTATE: begin
                if (i_index == i_ctrl.at) begin
                    n_value = i_head;
                end else if (i_index < i_ctrl.at) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* design/positional_list_store_unit.sv */
// Top level of the positional list store: command decode, cell chain, result register.
//
// Input channel: one command beat (mode, value_in, position) is taken when
// i_in_valid is high and o_in_stall is low. Output channel: result beats on
// o_out_valid / i_out_stall, each carrying status, element count and, during
// read-out, one element with its index; last marks the final beat of a command.
//
// Insert and delete commands shift the slots from the target position onward
// by one place at once, and the single result is registered at acceptance.
// A read-out of N elements gives N beats, one per cycle while the receiver
// does not stall; the chain rotates by one slot per beat, so the head slot
// always holds the element being sent and the list is back in order after the
// last beat. A new command is taken once the read-out has finished and the
// result register is free or being drained in the same cycle.
//
// Reset clears the element count, the read-out sequencer and the result
// valid flag; slot contents and the result data are not cleared. While the
// receiver stalls, the result register holds its beat and the input side stalls as well.
module positional_list_store_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pls_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pls_pkg::t_out_beat o_out_data
);

    localparam int DEPTH = pls_pkg::DEPTH;
    localparam int IDX_W = pls_pkg::IDX_W;
    localparam int CNT_W = pls_pkg::CNT_W;

    logic [CNT_W-1:0]    r_len,  n_len;
    logic                r_busy, n_busy;
    logic [IDX_W-1:0]    r_idx,  n_idx;
    logic                r_out_valid, n_out_valid;
    pls_pkg::t_out_beat  r_out,  n_out;

    pls_pkg::t_cell_ctrl ctrl;
    logic signed [31:0]  cell_val [DEPTH];

    logic                in_acc;
    logic                out_free;
    logic [8:0]          len9;
    logic [8:0]          pos_m1;
    logic [8:0]          tgt;
    logic                bad;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_busy || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign len9       = 9'(r_len);
    assign pos_m1     = 9'(i_in_data.position) - 9'd1;

    always_comb begin
        n_len       = r_len;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ctrl.op     = pls_pkg::CH_HOLD;
        ctrl.at     = '0;
        tgt         = '0;
        bad         = 1'b0;

        if (r_busy && out_free) begin
            n_out_valid           = 1'b1;
            n_out.status          = pls_pkg::ST_OK;
            n_out.element_count   = 7'(r_len);
            n_out.element_valid   = 1'b1;
            n_out.value_out       = cell_val[0];
            n_out.element_index   = 6'(r_idx);
            n_out.last            = (CNT_W'(r_idx) == r_len - CNT_W'(1));
            ctrl.op               = pls_pkg::CH_ROTATE;
            ctrl.at               = IDX_W'(r_len - CNT_W'(1));
            n_idx                 = r_idx + IDX_W'(1);
            if (n_out.last) begin
                n_busy = 1'b0;
            end
        end else if (in_acc) begin
            n_out_valid         = 1'b1;
            n_out.status        = pls_pkg::ST_OK;
            n_out.element_valid = 1'b0;
            n_out.value_out     = '0;
            n_out.element_index = '0;
            n_out.last          = 1'b1;
            unique case (i_in_data.mode) inside
                pls_pkg::MODE_INS_FIRST, pls_pkg::MODE_INS_LAST,
                pls_pkg::MODE_INS_POS: begin
                    if (i_in_data.mode == pls_pkg::MODE_INS_FIRST) begin
                        tgt = '0;
                    end else if (i_in_data.mode == pls_pkg::MODE_INS_LAST) begin
                        tgt = len9;
                    end else begin
                        tgt = pos_m1;
                        bad = (i_in_data.position == 8'd0);
                    end
                    if (bad || tgt > len9) begin
                        n_out.status = pls_pkg::ST_BADPOS;
                    end else if (r_len == CNT_W'(DEPTH)) begin
                        n_out.status = pls_pkg::ST_FULL;
                    end else begin
                        ctrl.op = pls_pkg::CH_INSERT;
                        ctrl.at = tgt[IDX_W-1:0];
                        n_len   = r_len + CNT_W'(1);
                    end
                end
                pls_pkg::MODE_DEL_FIRST, pls_pkg::MODE_DEL_LAST,
                pls_pkg::MODE_DEL_POS: begin
                    if (i_in_data.mode == pls_pkg::MODE_DEL_FIRST) begin
                        tgt = '0;
                    end else if (i_in_data.mode == pls_pkg::MODE_DEL_LAST) begin
                        tgt = len9 - 9'd1;
                    end else begin
                        tgt = pos_m1;
                        bad = (i_in_data.position == 8'd0);
                    end
                    if (r_len == '0) begin
                        n_out.status = pls_pkg::ST_EMPTY;
                    end else if (bad || tgt >= len9) begin
                        n_out.status = pls_pkg::ST_BADPOS;
                    end else begin
                        ctrl.op = pls_pkg::CH_DELETE;
                        ctrl.at = tgt[IDX_W-1:0];
                        n_len   = r_len - CNT_W'(1);
                    end
                end
                pls_pkg::MODE_READ: begin
                    if (r_len == '0) begin
                        n_out.status = pls_pkg::ST_EMPTY;
                    end else begin
                        n_out.element_valid = 1'b1;
                        n_out.value_out     = cell_val[0];
                        n_out.last          = (r_len == CNT_W'(1));
                        ctrl.op             = pls_pkg::CH_ROTATE;
                        ctrl.at             = IDX_W'(r_len - CNT_W'(1));
                        n_idx               = IDX_W'(1);
                        n_busy              = (r_len != CNT_W'(1));
                    end
                end
                default: ;
            endcase
            n_out.element_count = 7'(n_len);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pls_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_index (IDX_W'(g)),
            .i_left  (cell_val[(g == 0) ? 0 : g - 1]),
            .i_right (cell_val[(g == DEPTH - 1) ? g : g + 1]),
            .i_head  (cell_val[0]),
            .i_new   (i_in_data.value_in),
            .o_value (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
